// ----- rtl/mffc_pkg.sv -----
package mffc_pkg;

    // grid geometry and store sizes
    localparam int GRID_W      = 16;
    localparam int GRID_H      = 16;
    localparam int CELLS       = GRID_W * GRID_H;
    localparam int CELL_W      = $clog2(CELLS);
    localparam int LAYERS      = 2;
    localparam int LAYER_W     = 1;
    localparam int COST_DEPTH  = LAYERS * CELLS;
    localparam int COST_AW     = LAYER_W + CELL_W;
    localparam int COST_W      = 10;
    localparam logic [COST_W-1:0] COST_CEIL = 10'd1023;
    localparam int QUEUE_DEPTH = 1024;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    localparam int WORK_W      = 17;
    localparam logic [WORK_W-1:0] WORK_LIMIT = 17'd65536;

    // request codes
    localparam logic [2:0] REQ_SET_COST = 3'd0;
    localparam logic [2:0] REQ_READ     = 3'd1;
    localparam logic [2:0] REQ_WALL     = 3'd2;
    localparam logic [2:0] REQ_VIRTUAL  = 3'd3;
    localparam logic [2:0] REQ_FILL     = 3'd4;
    localparam logic [2:0] REQ_REPAIR   = 3'd5;

    // edge states
    localparam logic [1:0] EDGE_UNKNOWN = 2'd0;
    localparam logic [1:0] EDGE_OPEN    = 2'd1;
    localparam logic [1:0] EDGE_WALL    = 2'd2;
    localparam logic [1:0] EDGE_VIRTUAL = 2'd3;

    // sides
    localparam logic [1:0] SIDE_RIGHT = 2'd0;
    localparam logic [1:0] SIDE_UP    = 2'd1;
    localparam logic [1:0] SIDE_LEFT  = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  pos_x;
        logic [3:0]  pos_y;
        logic [1:0]  side;
        logic        layer;
        logic [9:0]  cost_value;
        logic        wall_present;
    } req_t;

    typedef struct packed {
        logic [9:0]  cell_cost;
        logic [7:0]  cell_walls;
        logic        wall_updated;
        logic        queue_overflow;
    } rsp_t;

    typedef struct packed {
        logic              ok;
        logic [CELL_W-1:0] idx;
    } nbr_t;

    // cell across one edge, ok low when it lies outside the grid
    function automatic nbr_t neighbour(input logic [CELL_W-1:0] cidx, input logic [1:0] s);
        nbr_t       r;
        logic [3:0] x;
        logic [3:0] y;
        x = cidx[3:0];
        y = cidx[7:4];
        r.ok  = 1'b0;
        r.idx = cidx;
        unique case (s)
            SIDE_RIGHT:
            begin
                r.ok  = (x != 4'(GRID_W - 1));
                r.idx = {y, 4'(x + 4'd1)};
            end
            SIDE_UP:
            begin
                r.ok  = (y != 4'(GRID_H - 1));
                r.idx = {4'(y + 4'd1), x};
            end
            SIDE_LEFT:
            begin
                r.ok  = (x != 4'd0);
                r.idx = {y, 4'(x - 4'd1)};
            end
            default:
            begin
                r.ok  = (y != 4'd0);
                r.idx = {4'(y - 4'd1), x};
            end
        endcase
        return r;
    endfunction

    function automatic logic [COST_W-1:0] inc_sat(input logic [COST_W-1:0] c);
        return (c >= COST_CEIL) ? COST_CEIL : COST_W'(c + 1'b1);
    endfunction

    // wall word after reset: border edges walled, rest unknown
    function automatic logic [7:0] wall_reset(input logic [CELL_W-1:0] cidx);
        logic [7:0] w;
        w = {4{EDGE_UNKNOWN}};
        if (cidx[3:0] == 4'(GRID_W - 1)) w[1:0] = EDGE_WALL;
        if (cidx[7:4] == 4'(GRID_H - 1)) w[3:2] = EDGE_WALL;
        if (cidx[3:0] == 4'd0)           w[5:4] = EDGE_WALL;
        if (cidx[7:4] == 4'd0)           w[7:6] = EDGE_WALL;
        return w;
    endfunction

endpackage

// ----- rtl/maze_flood_fill_costmap_core.sv -----
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_ready | mffc_pkg::req_t
// rsp     | out       | rsp_valid/rsp_ready | mffc_pkg::rsp_t
//
// one request at a time; cost, wall and work queue live in single-port-read RAMs
// simple requests pass through read, execute, neighbour mirror and result read states; fill
// dequeues a cell, reads it, then reads and compares the cost across each open edge, repair
// may walk the edges twice; a finished fill or repair reads the result before responding
// after reset a clearing pass over every cost entry loads costs and border walls; req_ready low
// a finished beat waits in the output register, the next request is taken meanwhile
module maze_flood_fill_costmap_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  mffc_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output mffc_pkg::rsp_t rsp
);

    typedef enum logic [12:0] {
        ST_CLEAR  = 13'b0000000000001,
        ST_IDLE   = 13'b0000000000010,
        ST_S_RD   = 13'b0000000000100,
        ST_S_EXE  = 13'b0000000001000,
        ST_S_NB   = 13'b0000000010000,
        ST_POP    = 13'b0000000100000,
        ST_PRD    = 13'b0000001000000,
        ST_PLATCH = 13'b0000010000000,
        ST_NRD    = 13'b0000100000000,
        ST_NCMP   = 13'b0001000000000,
        ST_EVAL   = 13'b0010000000000,
        ST_FIN_RD = 13'b0100000000000,
        ST_FIN    = 13'b1000000000000
    } state_t;

    state_t                             state_reg, state_next;
    mffc_pkg::req_t                     req_reg, req_next;
    logic [mffc_pkg::CELL_W-1:0]        cell_reg, cell_next;
    logic [7:0]                         cwall_reg, cwall_next;
    logic [mffc_pkg::COST_W-1:0]        ccost_reg, ccost_next;
    logic [mffc_pkg::COST_W-1:0]        lowest_reg, lowest_next;
    logic [1:0]                         side_reg, side_next;
    logic                               phase_reg, phase_next;
    logic [mffc_pkg::COST_AW-1:0]       clr_reg, clr_next;
    logic [mffc_pkg::QPTR_W-1:0]        head_reg, head_next;
    logic [mffc_pkg::QPTR_W-1:0]        tail_reg, tail_next;
    logic [mffc_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic [mffc_pkg::WORK_W-1:0]        work_reg, work_next;
    logic                               ovf_reg, ovf_next;
    logic                               upd_reg, upd_next;
    logic                               nbw_reg, nbw_next;
    logic [1:0]                         nbval_reg, nbval_next;
    mffc_pkg::rsp_t                     rsp_reg, rsp_next;
    logic                               rsp_valid_reg, rsp_valid_next;

    logic                               cost_we, cost_re;
    logic [mffc_pkg::COST_AW-1:0]       cost_waddr, cost_raddr;
    logic [mffc_pkg::COST_W-1:0]        cost_wdata, cost_rdata;
    logic                               wall_we, wall_re;
    logic [mffc_pkg::CELL_W-1:0]        wall_waddr, wall_raddr;
    logic [7:0]                         wall_wdata, wall_rdata;
    logic                               q_we, q_re;
    logic [mffc_pkg::QPTR_W-1:0]        q_waddr, q_raddr;
    logic [mffc_pkg::CELL_W-1:0]        q_wdata, q_rdata;

    logic [mffc_pkg::CELL_W-1:0]        req_cell;
    mffc_pkg::nbr_t                     nb_walk, nb_req;
    logic                               passable;
    logic                               is_fill;
    logic                               push;
    logic [mffc_pkg::CELL_W-1:0]        push_cell;
    logic [mffc_pkg::COST_W-1:0]        fill_cost, target;
    logic [1:0]                         edge_cur, nb_side;
    logic [7:0]                         wall_mod;
    state_t                             after_side;

    mffc_ram #(.WIDTH(mffc_pkg::COST_W), .DEPTH(mffc_pkg::COST_DEPTH)) u_cost_ram (
        .clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
        .re(cost_re), .raddr(cost_raddr), .rdata(cost_rdata)
    );

    mffc_ram #(.WIDTH(8), .DEPTH(mffc_pkg::CELLS)) u_wall_ram (
        .clk(clk), .we(wall_we), .waddr(wall_waddr), .wdata(wall_wdata),
        .re(wall_re), .raddr(wall_raddr), .rdata(wall_rdata)
    );

    mffc_ram #(.WIDTH(mffc_pkg::CELL_W), .DEPTH(mffc_pkg::QUEUE_DEPTH)) u_queue_ram (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
    );

    // shared decode
    always_comb
    begin
        req_cell   = {req_reg.pos_y, req_reg.pos_x};
        nb_walk    = mffc_pkg::neighbour(cell_reg, side_reg);
        nb_req     = mffc_pkg::neighbour(req_cell, req_reg.side);
        passable   = nb_walk.ok && (cwall_reg[{side_reg, 1'b0} +: 2] != mffc_pkg::EDGE_WALL);
        is_fill    = (req_reg.req_type == mffc_pkg::REQ_FILL);
        fill_cost  = mffc_pkg::inc_sat(ccost_reg);
        target     = mffc_pkg::inc_sat(lowest_reg);
        edge_cur   = wall_rdata[{req_reg.side, 1'b0} +: 2];
        nb_side    = 2'(req_reg.side + 2'd2);
        wall_mod   = wall_rdata;
        wall_mod[{nb_side, 1'b0} +: 2] = nbval_reg;
        after_side = (side_reg != 2'd3) ? ST_NRD
                   : ((is_fill || phase_reg) ? ST_POP : ST_EVAL);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        cell_next      = cell_reg;
        cwall_next     = cwall_reg;
        ccost_next     = ccost_reg;
        lowest_next    = lowest_reg;
        side_next      = side_reg;
        phase_next     = phase_reg;
        clr_next       = clr_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        work_next      = work_reg;
        ovf_next       = ovf_reg;
        upd_next       = upd_reg;
        nbw_next       = nbw_reg;
        nbval_next     = nbval_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cost_we        = 1'b0;
        cost_waddr     = {req_reg.layer, req_cell};
        cost_wdata     = req_reg.cost_value;
        cost_re        = 1'b0;
        cost_raddr     = {req_reg.layer, req_cell};
        wall_we        = 1'b0;
        wall_waddr     = req_cell;
        wall_wdata     = wall_rdata;
        wall_re        = 1'b0;
        wall_raddr     = req_cell;
        q_we           = 1'b0;
        q_waddr        = tail_reg;
        q_wdata        = nb_walk.idx;
        q_re           = 1'b0;
        q_raddr        = head_reg;
        push           = 1'b0;
        push_cell      = nb_walk.idx;

        unique case (state_reg)
            ST_CLEAR:
            begin
                cost_we    = 1'b1;
                cost_waddr = clr_reg;
                cost_wdata = mffc_pkg::COST_CEIL;
                wall_we    = 1'b1;
                wall_waddr = clr_reg[mffc_pkg::CELL_W-1:0];
                wall_wdata = mffc_pkg::wall_reset(clr_reg[mffc_pkg::CELL_W-1:0]);
                clr_next   = mffc_pkg::COST_AW'(clr_reg + 1'b1);
                if (clr_reg == mffc_pkg::COST_AW'(mffc_pkg::COST_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    ovf_next = 1'b0;
                    upd_next = 1'b0;
                    nbw_next = 1'b0;
                    work_next = '0;
                    if (req.req_type == mffc_pkg::REQ_FILL ||
                        req.req_type == mffc_pkg::REQ_REPAIR)
                    begin
                        // seed queue with the start cell
                        q_we       = 1'b1;
                        q_waddr    = '0;
                        q_wdata    = {req.pos_y, req.pos_x};
                        head_next  = '0;
                        tail_next  = mffc_pkg::QPTR_W'(1);
                        count_next = mffc_pkg::QCNT_W'(1);
                        state_next = ST_POP;
                    end
                    else
                    begin
                        state_next = ST_S_RD;
                    end
                end
            end
            ST_S_RD:
            begin
                wall_re    = 1'b1;
                state_next = ST_S_EXE;
            end
            ST_S_EXE:
            begin
                // cell side of cost, wall and virtual requests
                wall_re    = 1'b1;
                wall_raddr = nb_req.idx;
                wall_wdata = wall_rdata;
                state_next = ST_S_NB;
                if (req_reg.req_type == mffc_pkg::REQ_SET_COST)
                begin
                    cost_we = 1'b1;
                end
                else if (req_reg.req_type == mffc_pkg::REQ_WALL)
                begin
                    if (edge_cur != mffc_pkg::EDGE_WALL && edge_cur != mffc_pkg::EDGE_VIRTUAL)
                    begin
                        nbval_next = req_reg.wall_present ? mffc_pkg::EDGE_WALL
                                                          : mffc_pkg::EDGE_OPEN;
                        wall_wdata[{req_reg.side, 1'b0} +: 2] = nbval_next;
                        wall_we  = 1'b1;
                        nbw_next = 1'b1;
                        upd_next = req_reg.wall_present;
                    end
                end
                else if (req_reg.req_type == mffc_pkg::REQ_VIRTUAL)
                begin
                    nbval_next = mffc_pkg::EDGE_VIRTUAL;
                    wall_wdata[{req_reg.side, 1'b0} +: 2] = mffc_pkg::EDGE_VIRTUAL;
                    wall_we  = 1'b1;
                    nbw_next = 1'b1;
                end
            end
            ST_S_NB:
            begin
                // mirror the edge into the neighbor cell
                wall_we    = nbw_reg && nb_req.ok;
                wall_waddr = nb_req.idx;
                wall_wdata = wall_mod;
                state_next = ST_FIN_RD;
            end
            ST_POP:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_FIN_RD;
                end
                else if (work_reg >= mffc_pkg::WORK_LIMIT)
                begin
                    ovf_next   = 1'b1;
                    state_next = ST_FIN_RD;
                end
                else
                begin
                    q_re       = 1'b1;
                    head_next  = mffc_pkg::QPTR_W'(head_reg + 1'b1);
                    count_next = mffc_pkg::QCNT_W'(count_reg - 1'b1);
                    work_next  = mffc_pkg::WORK_W'(work_reg + 1'b1);
                    state_next = ST_PRD;
                end
            end
            ST_PRD:
            begin
                cell_next  = q_rdata;
                cost_re    = 1'b1;
                cost_raddr = {req_reg.layer, q_rdata};
                wall_re    = 1'b1;
                wall_raddr = q_rdata;
                state_next = ST_PLATCH;
            end
            ST_PLATCH:
            begin
                cwall_next  = wall_rdata;
                ccost_next  = cost_rdata;
                lowest_next = mffc_pkg::COST_CEIL;
                side_next   = '0;
                phase_next  = 1'b0;
                state_next  = ST_NRD;
            end
            ST_NRD:
            begin
                if (passable)
                begin
                    cost_re    = 1'b1;
                    cost_raddr = {req_reg.layer, nb_walk.idx};
                    state_next = ST_NCMP;
                end
                else
                begin
                    side_next  = 2'(side_reg + 2'd1);
                    state_next = after_side;
                end
            end
            ST_NCMP:
            begin
                // neighbor cost is on the read port
                if (is_fill)
                begin
                    if (cost_rdata > fill_cost)
                    begin
                        cost_we    = 1'b1;
                        cost_waddr = {req_reg.layer, nb_walk.idx};
                        cost_wdata = fill_cost;
                        push       = 1'b1;
                    end
                end
                else if (!phase_reg)
                begin
                    if (cost_rdata < lowest_reg) lowest_next = cost_rdata;
                end
                else if ({1'b0, cost_rdata} == 11'({1'b0, ccost_reg} + 11'd1))
                begin
                    push = 1'b1;
                end
                side_next  = 2'(side_reg + 2'd1);
                state_next = after_side;
            end
            ST_EVAL:
            begin
                if (ccost_reg == target)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    cost_we    = 1'b1;
                    cost_waddr = {req_reg.layer, cell_reg};
                    cost_wdata = target;
                    phase_next = 1'b1;
                    side_next  = '0;
                    state_next = ST_NRD;
                end
            end
            ST_FIN_RD:
            begin
                cost_re    = 1'b1;
                wall_re    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.cell_cost      = cost_rdata;
                    rsp_next.cell_walls     = wall_rdata;
                    rsp_next.wall_updated   = upd_reg;
                    rsp_next.queue_overflow = ovf_reg;
                    rsp_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // enqueue with overflow drop
        if (push)
        begin
            if (count_reg >= mffc_pkg::QCNT_W'(mffc_pkg::QUEUE_DEPTH))
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                q_we       = 1'b1;
                q_waddr    = tail_reg;
                q_wdata    = push_cell;
                tail_next  = mffc_pkg::QPTR_W'(tail_reg + 1'b1);
                count_next = mffc_pkg::QCNT_W'(count_reg + 1'b1);
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            work_reg      <= '0;
            ovf_reg       <= 1'b0;
            upd_reg       <= 1'b0;
            nbw_reg       <= 1'b0;
            phase_reg     <= 1'b0;
            side_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            work_reg      <= work_next;
            ovf_reg       <= ovf_next;
            upd_reg       <= upd_next;
            nbw_reg       <= nbw_next;
            phase_reg     <= phase_next;
            side_reg      <= side_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        cell_reg   <= cell_next;
        cwall_reg  <= cwall_next;
        ccost_reg  <= ccost_next;
        lowest_reg <= lowest_next;
        nbval_reg  <= nbval_next;
        rsp_reg    <= rsp_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // queue occupancy never passes its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mffc_pkg::QCNT_W'(mffc_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    // a pop only happens from a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_re |-> (count_reg != '0))
        else $error("pop from empty queue");

    // the clearing pass keeps requests out
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !req_ready)
        else $error("request taken during clearing pass");

    // a result is loaded only when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_ready) |=> $stable(rsp_reg))
        else $error("pending result overwritten");

endmodule

// ----- rtl/mffc_ram.sv -----
module mffc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read that holds when idle
    always_ff @(posedge clk)
    begin
        if (we) mem[waddr] <= wdata;
        if (re) rdata <= mem[raddr];
    end

endmodule

// ----- sim/maze_flood_fill_costmap_core_checker.sv -----
module maze_flood_fill_costmap_core_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_ready,
    input  mffc_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_ready,
    input  mffc_pkg::rsp_t rsp,
    output int             errors,
    output int             pending
);

    // mirror of the cost map, wall words and work queue
    logic [mffc_pkg::COST_W-1:0] cost_mem [mffc_pkg::COST_DEPTH];
    logic [7:0]                  wall_mem [mffc_pkg::CELLS];
    int                          work_q [mffc_pkg::QUEUE_DEPTH];
    int                          q_head;
    int                          q_tail;
    int                          q_count;
    bit                          overflow_seen;
    mffc_pkg::rsp_t              expected_rsp [$];

    function automatic logic [1:0] edge_state(input int c, input int s);
        return wall_mem[c][2*s +: 2];
    endfunction

    function automatic void put_edge(input int c, input int s, input logic [1:0] v);
        wall_mem[c][2*s +: 2] = v;
    endfunction

    // cell across an edge, -1 when it leaves the grid
    function automatic int cell_across(input int c, input int s);
        int x;
        int y;
        x = c % mffc_pkg::GRID_W;
        y = c / mffc_pkg::GRID_W;
        case (s)
            0: if (x == mffc_pkg::GRID_W - 1) return -1; else x++;
            1: if (y == mffc_pkg::GRID_H - 1) return -1; else y++;
            2: if (x == 0) return -1; else x--;
            default: if (y == 0) return -1; else y--;
        endcase
        return y * mffc_pkg::GRID_W + x;
    endfunction

    // only real walls and the border block travel
    function automatic int open_way(input int c, input int s);
        if (edge_state(c, s) == mffc_pkg::EDGE_WALL)
            return -1;
        return cell_across(c, s);
    endfunction

    function automatic int cost_plus_one(input int c);
        return (c >= mffc_pkg::COST_CEIL) ? int'(mffc_pkg::COST_CEIL) : c + 1;
    endfunction

    function automatic void q_push(input int c);
        if (q_count >= mffc_pkg::QUEUE_DEPTH)
        begin
            overflow_seen = 1'b1;
            return;
        end
        work_q[q_tail] = c;
        q_tail = (q_tail + 1) % mffc_pkg::QUEUE_DEPTH;
        q_count++;
    endfunction

    function automatic int q_pop();
        int c;
        c = work_q[q_head];
        q_head = (q_head + 1) % mffc_pkg::QUEUE_DEPTH;
        q_count--;
        return c;
    endfunction

    // breadth-first lowering from a start cell
    function automatic void run_fill(input int start, input int base);
        int work;
        int c;
        int n;
        int nc;
        work = 0;
        q_head = 0; q_tail = 0; q_count = 0;
        q_push(start);
        while (q_count > 0)
        begin
            if (work >= mffc_pkg::WORK_LIMIT)
            begin
                overflow_seen = 1'b1;
                break;
            end
            work++;
            c = q_pop() % mffc_pkg::CELLS;
            for (int s = 0; s < 4; s++)
            begin
                n = open_way(c, s);
                if (n < 0) continue;
                nc = cost_plus_one(cost_mem[base + c]);
                if (cost_mem[base + n] > nc)
                begin
                    cost_mem[base + n] = mffc_pkg::COST_W'(nc);
                    q_push(n);
                end
            end
        end
        q_head = 0; q_tail = 0; q_count = 0;
    endfunction

    // local re-settle of costs around a cell
    function automatic void run_repair(input int start, input int base);
        int work;
        int c;
        int n;
        int lowest;
        int target;
        int old;
        work = 0;
        q_head = 0; q_tail = 0; q_count = 0;
        q_push(start);
        while (q_count > 0)
        begin
            if (work >= mffc_pkg::WORK_LIMIT)
            begin
                overflow_seen = 1'b1;
                break;
            end
            work++;
            c = q_pop() % mffc_pkg::CELLS;
            lowest = mffc_pkg::COST_CEIL;
            for (int s = 0; s < 4; s++)
            begin
                n = open_way(c, s);
                if (n >= 0 && cost_mem[base + n] < lowest) lowest = cost_mem[base + n];
            end
            target = cost_plus_one(lowest);
            old = cost_mem[base + c];
            if (old == target) continue;
            cost_mem[base + c] = mffc_pkg::COST_W'(target);
            for (int s = 0; s < 4; s++)
            begin
                n = open_way(c, s);
                if (n >= 0 && int'(cost_mem[base + n]) == old + 1) q_push(n);
            end
        end
        q_head = 0; q_tail = 0; q_count = 0;
    endfunction

    // apply one request to the mirror and form its response
    function automatic mffc_pkg::rsp_t predict_cell_result(input mffc_pkg::req_t r);
        mffc_pkg::rsp_t o;
        int             c;
        int             base;
        int             n;
        logic [1:0]     e;
        logic [1:0]     v;
        o = '0;
        overflow_seen = 1'b0;
        c = int'(r.pos_y) * mffc_pkg::GRID_W + int'(r.pos_x);
        base = int'(r.layer) * mffc_pkg::CELLS;
        case (r.req_type)
            mffc_pkg::REQ_SET_COST:
                cost_mem[base + c] = (r.cost_value > mffc_pkg::COST_CEIL) ?
                                     mffc_pkg::COST_CEIL : r.cost_value;
            mffc_pkg::REQ_WALL:
            begin
                e = edge_state(c, r.side);
                if (e != mffc_pkg::EDGE_WALL && e != mffc_pkg::EDGE_VIRTUAL)
                begin
                    v = r.wall_present ? mffc_pkg::EDGE_WALL : mffc_pkg::EDGE_OPEN;
                    put_edge(c, r.side, v);
                    n = cell_across(c, r.side);
                    if (n >= 0) put_edge(n, (r.side + 2) % 4, v);
                    o.wall_updated = r.wall_present;
                end
            end
            mffc_pkg::REQ_VIRTUAL:
            begin
                put_edge(c, r.side, mffc_pkg::EDGE_VIRTUAL);
                n = cell_across(c, r.side);
                if (n >= 0) put_edge(n, (r.side + 2) % 4, mffc_pkg::EDGE_VIRTUAL);
            end
            mffc_pkg::REQ_FILL:   run_fill(c, base);
            mffc_pkg::REQ_REPAIR: run_repair(c, base);
            default: ;
        endcase
        o.cell_cost = cost_mem[base + c];
        o.cell_walls = wall_mem[c];
        o.queue_overflow = (r.req_type == mffc_pkg::REQ_FILL ||
                            r.req_type == mffc_pkg::REQ_REPAIR) && overflow_seen;
        return o;
    endfunction

    // reset state, then predict on request beats and compare on response beats
    always @(posedge clk or negedge rst_n)
    begin
        mffc_pkg::rsp_t e;
        if (!rst_n)
        begin
            errors = 0;
            expected_rsp.delete();
            for (int i = 0; i < mffc_pkg::COST_DEPTH; i++) cost_mem[i] = mffc_pkg::COST_CEIL;
            for (int i = 0; i < mffc_pkg::CELLS; i++)
            begin
                wall_mem[i] = '0;
                if (i % mffc_pkg::GRID_W == 0) wall_mem[i][5:4] = mffc_pkg::EDGE_WALL;
                if (i % mffc_pkg::GRID_W == mffc_pkg::GRID_W - 1)
                    wall_mem[i][1:0] = mffc_pkg::EDGE_WALL;
                if (i / mffc_pkg::GRID_W == 0) wall_mem[i][7:6] = mffc_pkg::EDGE_WALL;
                if (i / mffc_pkg::GRID_W == mffc_pkg::GRID_H - 1)
                    wall_mem[i][3:2] = mffc_pkg::EDGE_WALL;
            end
            q_head = 0; q_tail = 0; q_count = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $error("response beat with nothing expected: %h", rsp);
                    errors++;
                end
                else
                begin
                    e = expected_rsp.pop_front();
                    if (rsp.cell_cost !== e.cell_cost)
                    begin
                        $error("cell_cost expected %0d actual %0d", e.cell_cost, rsp.cell_cost);
                        errors++;
                    end
                    if (rsp.cell_walls !== e.cell_walls)
                    begin
                        $error("cell_walls expected %h actual %h", e.cell_walls, rsp.cell_walls);
                        errors++;
                    end
                    if (rsp.wall_updated !== e.wall_updated)
                    begin
                        $error("wall_updated expected %0d actual %0d",
                               e.wall_updated, rsp.wall_updated);
                        errors++;
                    end
                    if (rsp.queue_overflow !== e.queue_overflow)
                    begin
                        $error("queue_overflow expected %0d actual %0d",
                               e.queue_overflow, rsp.queue_overflow);
                        errors++;
                    end
                end
            end
            if (req_valid && req_ready)
                expected_rsp.push_back(predict_cell_result(req));
        end
        pending = expected_rsp.size();
    end

endmodule

// ----- sim/maze_flood_fill_costmap_core_test.sv -----
module maze_flood_fill_costmap_core_test;

    localparam int STALL_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 270;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    mffc_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_ready;
    mffc_pkg::rsp_t rsp;
    int             errors;
    int             pending;
    int             sent_cnt;
    int             idle_cycles;
    bit             quiet_tail;

    maze_flood_fill_costmap_core DUT (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    maze_flood_fill_costmap_core_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        sent_cnt = 0;
        quiet_tail = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // offer one request beat, then maybe a gap
    task automatic send_beat(input mffc_pkg::req_t r);
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        sent_cnt++;
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    function automatic mffc_pkg::req_t make_req(input logic [2:0] kind, input int x,
                                                input int y, input int s, input int l,
                                                input int v, input int w);
        mffc_pkg::req_t r;
        r.req_type = kind;
        r.pos_x = 4'(x);
        r.pos_y = 4'(y);
        r.side = 2'(s);
        r.layer = 1'(l);
        r.cost_value = 10'(v);
        r.wall_present = 1'(w);
        return r;
    endfunction

    // mostly coherent maze work with random content, some pure noise
    function automatic mffc_pkg::req_t random_req();
        mffc_pkg::req_t r;
        int             pick;
        r = mffc_pkg::req_t'(($bits(mffc_pkg::req_t))'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 22)
        begin
            r.req_type = mffc_pkg::REQ_SET_COST;
            if ($urandom_range(0, 2) != 0) r.cost_value = 10'($urandom_range(0, 20));
        end
        else if (pick < 47) r.req_type = mffc_pkg::REQ_WALL;
        else if (pick < 55) r.req_type = mffc_pkg::REQ_VIRTUAL;
        else if (pick < 70) r.req_type = mffc_pkg::REQ_FILL;
        else if (pick < 82) r.req_type = mffc_pkg::REQ_REPAIR;
        else if (pick < 92) r.req_type = mffc_pkg::REQ_READ;
        else r.req_type = 3'($urandom_range(6, 7));
        return r;
    endfunction

    // receiver: random stalls, one long hold-off, none at the tail
    initial
    begin
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && sent_cnt >= 60)
            begin
                held = 1'b1;
                rsp_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: cost extremes, every request kind, border and refused edges
        send_beat(make_req(mffc_pkg::REQ_READ, 0, 0, 0, 0, 0, 0));
        send_beat(make_req(mffc_pkg::REQ_SET_COST, 15, 15, 3, 1, 1023, 1));
        send_beat(make_req(mffc_pkg::REQ_SET_COST, 0, 0, 0, 0, 0, 0));
        send_beat(make_req(mffc_pkg::REQ_SET_COST, 5, 5, 0, 1, 0, 0));
        send_beat(make_req(mffc_pkg::REQ_WALL, 0, 0, 2, 0, 0, 1));
        send_beat(make_req(mffc_pkg::REQ_WALL, 15, 15, 1, 0, 0, 0));
        send_beat(make_req(mffc_pkg::REQ_WALL, 3, 3, 0, 0, 0, 1));
        send_beat(make_req(mffc_pkg::REQ_WALL, 4, 3, 2, 0, 0, 0));
        send_beat(make_req(mffc_pkg::REQ_WALL, 3, 4, 1, 0, 0, 0));
        send_beat(make_req(mffc_pkg::REQ_VIRTUAL, 6, 6, 3, 0, 0, 0));
        send_beat(make_req(mffc_pkg::REQ_WALL, 6, 5, 1, 0, 0, 1));
        send_beat(make_req(mffc_pkg::REQ_VIRTUAL, 15, 0, 0, 1, 0, 0));
        send_beat(make_req(mffc_pkg::REQ_FILL, 0, 0, 0, 0, 0, 0));
        send_beat(make_req(mffc_pkg::REQ_READ, 15, 15, 0, 0, 0, 0));
        send_beat(make_req(mffc_pkg::REQ_FILL, 5, 5, 1, 1, 0, 0));
        send_beat(make_req(mffc_pkg::REQ_SET_COST, 2, 2, 0, 0, 900, 0));
        send_beat(make_req(mffc_pkg::REQ_REPAIR, 2, 2, 0, 0, 0, 0));
        send_beat(make_req(mffc_pkg::REQ_SET_COST, 0, 0, 0, 0, 40, 0));
        send_beat(make_req(mffc_pkg::REQ_REPAIR, 0, 0, 0, 0, 0, 0));
        send_beat(make_req(mffc_pkg::REQ_FILL, 9, 9, 0, 1, 0, 0));
        send_beat(make_req(3'd6, 7, 7, 2, 1, 1023, 1));
        send_beat(make_req(3'd7, 8, 8, 3, 0, 512, 0));

        // random part, last stretch without gaps on either side
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - 40) quiet_tail = 1'b1;
            send_beat(random_req());
        end
        req_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mffc_pkg.sv
rtl/mffc_ram.sv
rtl/maze_flood_fill_costmap_core.sv
sim/maze_flood_fill_costmap_core_checker.sv
sim/maze_flood_fill_costmap_core_test.sv
